[design/nvwb_pkg.sv]
`timescale 1ns / 1ps
// nvwb_pkg: shared constants, codes and types for the NVRAM write-back manager.
// Used by nvwb_ctrl, nvwb_datapath and nvram_write_back_manager; no dependencies.
package nvwb_pkg;

   localparam int MAX_BLOCKS = 8;
   localparam int BLK_W      = 3;                       // block id field width
   localparam int NUM_IDS    = 2 ** BLK_W;
   localparam int MGD_LIMIT  = (MAX_BLOCKS < NUM_IDS) ? MAX_BLOCKS : NUM_IDS;
   localparam int CNT_W      = 4;                       // managed count / dirty count
   localparam int STAT_W     = 32;
   localparam int NUM_STATS  = 6;
   localparam int CSR_W      = 8;

   // request opcodes
   localparam logic [2:0] OP_WRITE       = 3'd0;
   localparam logic [2:0] OP_TICK        = 3'd1;
   localparam logic [2:0] OP_FLUSH_ALL   = 3'd2;
   localparam logic [2:0] OP_FLUSH_ONE   = 3'd3;
   localparam logic [2:0] OP_RESTORE     = 3'd4;
   localparam logic [2:0] OP_COMMIT_DONE = 3'd5;
   localparam logic [2:0] OP_LOAD_DONE   = 3'd6;
   localparam logic [2:0] OP_QUERY       = 3'd7;

   // block status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOT_OK   = 3'd1;
   localparam logic [2:0] ST_SKIPPED  = 3'd2;
   localparam logic [2:0] ST_PENDING  = 3'd3;
   localparam logic [2:0] ST_DEFAULTS = 3'd4;

   // load outcomes
   localparam logic [1:0] LD_OK        = 2'd0;
   localparam logic [1:0] LD_MEDIA_CRC = 2'd2;          // this and above: integrity failure

   // result kinds
   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_COMMIT = 1'b1;

   // statistics counter indexes
   localparam int CNT_WRITES    = 0;
   localparam int CNT_SKIPPED   = 1;
   localparam int CNT_READS     = 2;
   localparam int CNT_INTEGRITY = 3;
   localparam int CNT_DEFAULTS  = 4;
   localparam int CNT_WFAIL     = 5;

   // configuration register indexes
   localparam logic CSR_BLOCKS_IN_USE  = 1'b0;
   localparam logic CSR_IMMEDIATE_MASK = 1'b1;
   localparam logic [CNT_W-1:0] BLOCKS_RESET = 4'd5;
   localparam logic [CSR_W-1:0] IMM_RESET    = 8'd9;

   // controller to datapath commands
   localparam logic [2:0] CMD_NONE        = 3'd0;
   localparam logic [2:0] CMD_CAPTURE     = 3'd1;
   localparam logic [2:0] CMD_SINGLE      = 3'd2;
   localparam logic [2:0] CMD_IDLE_OK     = 3'd3;
   localparam logic [2:0] CMD_TICK_START  = 3'd4;
   localparam logic [2:0] CMD_TICK_STEP   = 3'd5;
   localparam logic [2:0] CMD_FLUSH_START = 3'd6;
   localparam logic [2:0] CMD_FLUSH_STEP  = 3'd7;

   typedef logic [2:0] cmd_type;

   typedef struct packed {
      logic       slot_free;   // output register can take a result this cycle
      logic [2:0] op;          // opcode of the captured request
      logic       any_dirty;   // some managed block is dirty
      logic       scan_done;   // tick scan visited every managed block
      logic       scan_hit;    // block under the tick cursor is dirty
      logic       flush_hit;   // block under the flush index is dirty
      logic       flush_last;  // no dirty managed block above the flush index
   } dp_status_type;

endpackage

[design/nvwb_ctrl.sv]
`timescale 1ns / 1ps
// nvwb_ctrl: request sequencer for the NVRAM write-back manager.
// Depends on nvwb_pkg; drives commands into nvwb_datapath.
module nvwb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  nvwb_pkg::dp_status_type sts,
   output nvwb_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FLUSH  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = nvwb_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = nvwb_pkg::CMD_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.op == nvwb_pkg::OP_TICK) begin
               cmd      = nvwb_pkg::CMD_TICK_START;
               state_in = S_SCAN;
            end else if (sts.op == nvwb_pkg::OP_FLUSH_ALL) begin
               if (sts.any_dirty) begin
                  cmd      = nvwb_pkg::CMD_FLUSH_START;
                  state_in = S_FLUSH;
               end else if (sts.slot_free) begin
                  cmd      = nvwb_pkg::CMD_IDLE_OK;
                  state_in = S_IDLE;
               end
            end else if (sts.slot_free) begin
               cmd      = nvwb_pkg::CMD_SINGLE;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (sts.slot_free) begin
               if (sts.scan_done) begin
                  cmd      = nvwb_pkg::CMD_IDLE_OK;
                  state_in = S_IDLE;
               end else begin
                  cmd = nvwb_pkg::CMD_TICK_STEP;
                  if (sts.scan_hit) state_in = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (sts.slot_free) begin
               cmd = nvwb_pkg::CMD_FLUSH_STEP;
               if (sts.flush_hit && sts.flush_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/nvwb_datapath.sv]
`timescale 1ns / 1ps
// nvwb_datapath: block marks, statistics counters, config registers and result register.
// Depends on nvwb_pkg; commanded by nvwb_ctrl.
module nvwb_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  nvwb_pkg::cmd_type             cmd,
   output nvwb_pkg::dp_status_type       sts,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [nvwb_pkg::CSR_W-1:0]    csr_wdata,
   input  logic [2:0]                    req_op,
   input  logic [nvwb_pkg::BLK_W-1:0]    req_block_id,
   input  logic                          req_same_as_last,
   input  logic                          req_commit_ok,
   input  logic [1:0]                    req_load_status,
   input  logic [2:0]                    req_stat_select,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [nvwb_pkg::BLK_W-1:0]    rsp_out_block,
   output logic [2:0]                    rsp_status_code,
   output logic                          rsp_accepted,
   output logic [nvwb_pkg::CNT_W-1:0]    rsp_dirty_count,
   output logic [nvwb_pkg::STAT_W-1:0]   rsp_stat_value,
   output logic                          rsp_last
);

   localparam int N  = nvwb_pkg::NUM_IDS;
   localparam int BW = nvwb_pkg::BLK_W;
   localparam int CW = nvwb_pkg::CNT_W;
   localparam int SW = nvwb_pkg::STAT_W;
   localparam int NS = nvwb_pkg::NUM_STATS;

   // configuration
   logic [CW-1:0]             blocks_ff, blocks_in;
   logic [nvwb_pkg::CSR_W-1:0] imm_ff, imm_in;

   // captured request
   logic [2:0]    op_ff, op_in;
   logic [BW-1:0] id_ff, id_in;
   logic          same_ff, same_in;
   logic          cok_ff, cok_in;
   logic [1:0]    lst_ff, lst_in;
   logic [2:0]    sel_ff, sel_in;

   // block marks and scan state
   logic [N-1:0]  dirty_ff, dirty_in;
   logic [N-1:0]  wv_ff, wv_in;
   logic [2:0]    bstat_ff [N];
   logic [2:0]    bstat_in [N];
   logic [BW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] step_ff, step_in;
   logic [BW-1:0] fidx_ff, fidx_in;

   logic [SW-1:0] stat_ff [NS];
   logic [SW-1:0] stat_in [NS];
   logic [NS-1:0] bump;

   // result register
   logic          rv_ff, rv_in;
   logic          kind_ff, kind_in;
   logic [BW-1:0] blk_ff, blk_in;
   logic [2:0]    code_ff, code_in;
   logic          acc_ff, acc_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [SW-1:0] val_ff, val_in;
   logic          last_ff, last_in;

   logic [CW-1:0] n_mgd;
   logic [N-1:0]  mmask, dirty_m, above;
   logic          id_valid, slot_free, load;
   logic [SW-1:0] sel_val;
   logic [BW-1:0] cursor_nxt;

   assign n_mgd = (blocks_ff > CW'(nvwb_pkg::MGD_LIMIT)) ? CW'(nvwb_pkg::MGD_LIMIT) : blocks_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         mmask[i] = (CW'(i) < n_mgd);
         above[i] = (BW'(i) > fidx_ff);
      end
   end

   assign dirty_m   = dirty_ff & mmask;
   assign id_valid  = ({1'b0, id_ff} < n_mgd);
   assign slot_free = !rv_ff || rsp_ready;
   assign sel_val   = ({1'b0, sel_ff} < 4'(NS)) ? stat_ff[sel_ff] : '0;
   // wrap the round-robin cursor at the managed count
   assign cursor_nxt = ({1'b0, cursor_ff} + 4'd1 < n_mgd) ? cursor_ff + BW'(1) : '0;

   assign sts.slot_free  = slot_free;
   assign sts.op         = op_ff;
   assign sts.any_dirty  = |dirty_m;
   assign sts.scan_done  = (step_ff == n_mgd);
   assign sts.scan_hit   = dirty_ff[cursor_ff];
   assign sts.flush_hit  = dirty_m[fidx_ff];
   assign sts.flush_last = ~|(dirty_m & above);

   always_comb begin
      blocks_in = blocks_ff;
      imm_in    = imm_ff;
      if (csr_we) begin
         unique case (csr_index)
            nvwb_pkg::CSR_BLOCKS_IN_USE:  blocks_in = csr_wdata[CW-1:0];
            nvwb_pkg::CSR_IMMEDIATE_MASK: imm_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      op_in     = op_ff;
      id_in     = id_ff;
      same_in   = same_ff;
      cok_in    = cok_ff;
      lst_in    = lst_ff;
      sel_in    = sel_ff;
      dirty_in  = dirty_ff;
      wv_in     = wv_ff;
      bstat_in  = bstat_ff;
      cursor_in = cursor_ff;
      step_in   = step_ff;
      fidx_in   = fidx_ff;
      bump      = '0;
      load      = 1'b0;
      kind_in   = nvwb_pkg::KIND_REPLY;
      blk_in    = id_ff;
      code_in   = nvwb_pkg::ST_OK;
      acc_in    = 1'b1;
      val_in    = '0;
      last_in   = 1'b1;

      unique case (cmd)
         nvwb_pkg::CMD_NONE: ;
         nvwb_pkg::CMD_CAPTURE: begin
            op_in   = req_op;
            id_in   = req_block_id;
            same_in = req_same_as_last;
            cok_in  = req_commit_ok;
            lst_in  = req_load_status;
            sel_in  = req_stat_select;
         end
         nvwb_pkg::CMD_SINGLE: begin
            load = 1'b1;
            if (!id_valid) begin
               code_in = nvwb_pkg::ST_NOT_OK;
               acc_in  = 1'b0;
               if (op_ff == nvwb_pkg::OP_QUERY) val_in = sel_val;
            end else begin
               unique case (op_ff)
                  nvwb_pkg::OP_WRITE: begin
                     if (wv_ff[id_ff] && same_ff) begin
                        dirty_in[id_ff] = 1'b0;
                        bstat_in[id_ff] = nvwb_pkg::ST_SKIPPED;
                        bump[nvwb_pkg::CNT_SKIPPED] = 1'b1;
                        code_in = nvwb_pkg::ST_SKIPPED;
                     end else if (imm_ff[id_ff]) begin
                        bstat_in[id_ff] = nvwb_pkg::ST_PENDING;
                        kind_in = nvwb_pkg::KIND_COMMIT;
                        code_in = nvwb_pkg::ST_PENDING;
                     end else begin
                        dirty_in[id_ff] = 1'b1;
                        bstat_in[id_ff] = nvwb_pkg::ST_PENDING;
                        code_in = nvwb_pkg::ST_PENDING;
                     end
                  end
                  nvwb_pkg::OP_FLUSH_ONE: begin
                     if (dirty_ff[id_ff]) begin
                        kind_in = nvwb_pkg::KIND_COMMIT;
                        code_in = nvwb_pkg::ST_PENDING;
                     end
                  end
                  nvwb_pkg::OP_RESTORE: begin
                     dirty_in[id_ff] = 1'b1;
                     bstat_in[id_ff] = nvwb_pkg::ST_PENDING;
                     code_in = nvwb_pkg::ST_PENDING;
                  end
                  nvwb_pkg::OP_COMMIT_DONE: begin
                     if (cok_ff) begin
                        wv_in[id_ff]    = 1'b1;
                        dirty_in[id_ff] = 1'b0;
                        bstat_in[id_ff] = nvwb_pkg::ST_OK;
                        bump[nvwb_pkg::CNT_WRITES] = 1'b1;
                        code_in = nvwb_pkg::ST_OK;
                     end else begin
                        bstat_in[id_ff] = nvwb_pkg::ST_NOT_OK;
                        bump[nvwb_pkg::CNT_WFAIL] = 1'b1;
                        code_in = nvwb_pkg::ST_NOT_OK;
                     end
                  end
                  nvwb_pkg::OP_LOAD_DONE: begin
                     if (lst_ff == nvwb_pkg::LD_OK) begin
                        wv_in[id_ff]    = 1'b1;
                        bstat_in[id_ff] = nvwb_pkg::ST_OK;
                        bump[nvwb_pkg::CNT_READS] = 1'b1;
                        code_in = nvwb_pkg::ST_OK;
                     end else begin
                        // fallback to defaults; CRC failures also count as integrity
                        wv_in[id_ff]    = 1'b0;
                        bstat_in[id_ff] = nvwb_pkg::ST_DEFAULTS;
                        bump[nvwb_pkg::CNT_DEFAULTS]  = 1'b1;
                        bump[nvwb_pkg::CNT_INTEGRITY] = (lst_ff >= nvwb_pkg::LD_MEDIA_CRC);
                        code_in = nvwb_pkg::ST_DEFAULTS;
                     end
                  end
                  nvwb_pkg::OP_QUERY: begin
                     code_in = bstat_ff[id_ff];
                     val_in  = sel_val;
                  end
                  default: ;   // tick and flush-all never take this path
               endcase
            end
         end
         nvwb_pkg::CMD_IDLE_OK: begin
            load   = 1'b1;
            blk_in = '0;
         end
         nvwb_pkg::CMD_TICK_START: begin
            step_in   = '0;
            cursor_in = ({1'b0, cursor_ff} >= n_mgd) ? '0 : cursor_ff;
         end
         nvwb_pkg::CMD_TICK_STEP: begin
            step_in   = step_ff + CW'(1);
            cursor_in = cursor_nxt;
            if (dirty_ff[cursor_ff]) begin
               load    = 1'b1;
               kind_in = nvwb_pkg::KIND_COMMIT;
               blk_in  = cursor_ff;
               code_in = nvwb_pkg::ST_PENDING;
            end
         end
         nvwb_pkg::CMD_FLUSH_START: begin
            fidx_in = '0;
         end
         nvwb_pkg::CMD_FLUSH_STEP: begin
            fidx_in = fidx_ff + BW'(1);
            if (dirty_m[fidx_ff]) begin
               load    = 1'b1;
               kind_in = nvwb_pkg::KIND_COMMIT;
               blk_in  = fidx_ff;
               code_in = nvwb_pkg::ST_PENDING;
               last_in = sts.flush_last;
            end
         end
         default: ;
      endcase

      dcnt_in = CW'($countones(dirty_in & mmask));
   end

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         stat_in[k] = (bump[k] && (stat_ff[k] != '1)) ? stat_ff[k] + SW'(1) : stat_ff[k];
      end
   end

   assign rv_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= nvwb_pkg::BLOCKS_RESET;
         imm_ff    <= nvwb_pkg::IMM_RESET;
         dirty_ff  <= '0;
         wv_ff     <= '0;
         for (int i = 0; i < N; i++) bstat_ff[i] <= nvwb_pkg::ST_NOT_OK;
         for (int k = 0; k < NS; k++) stat_ff[k] <= '0;
         cursor_ff <= '0;
         step_ff   <= '0;
         fidx_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         blocks_ff <= blocks_in;
         imm_ff    <= imm_in;
         dirty_ff  <= dirty_in;
         wv_ff     <= wv_in;
         bstat_ff  <= bstat_in;
         stat_ff   <= stat_in;
         cursor_ff <= cursor_in;
         step_ff   <= step_in;
         fidx_ff   <= fidx_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      id_ff   <= id_in;
      same_ff <= same_in;
      cok_ff  <= cok_in;
      lst_ff  <= lst_in;
      sel_ff  <= sel_in;
      if (load) begin
         kind_ff <= kind_in;
         blk_ff  <= blk_in;
         code_ff <= code_in;
         acc_ff  <= acc_in;
         dcnt_ff <= dcnt_in;
         val_ff  <= val_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_block   = blk_ff;
   assign rsp_status_code = code_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_dirty_count = dcnt_ff;
   assign rsp_stat_value  = val_ff;
   assign rsp_last        = last_ff;

endmodule

[design/nvram_write_back_manager.sv]
`timescale 1ns / 1ps
// nvram_write_back_manager: top level of the NVRAM write-back manager.
// Depends on nvwb_pkg, nvwb_ctrl and nvwb_datapath.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  op, block_id, same_as_last, commit_ok,
//                                              load_status, stat_select
//   rsp_     out        rsp_valid / rsp_ready  result_kind, out_block, status_code,
//                                              accepted, dirty_count, stat_value, last
//   csr_     in         csr_we                 csr_index, csr_wdata
//
// One request at a time. A single-result request is captured, then executed into the
// result register. A tick walks one block per cycle from the round-robin cursor and
// stops at the first dirty block or after every managed block. Flush-all walks one
// block per cycle up to the last dirty block. A full result register stalls
// the sequencer until rsp_ready.
// Synchronous active-high reset; marks, counters and config return to reset values.
module nvram_write_back_manager (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic [nvwb_pkg::BLK_W-1:0]   req_block_id,
   input  logic                         req_same_as_last,
   input  logic                         req_commit_ok,
   input  logic [1:0]                   req_load_status,
   input  logic [2:0]                   req_stat_select,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_result_kind,
   output logic [nvwb_pkg::BLK_W-1:0]   rsp_out_block,
   output logic [2:0]                   rsp_status_code,
   output logic                         rsp_accepted,
   output logic [nvwb_pkg::CNT_W-1:0]   rsp_dirty_count,
   output logic [nvwb_pkg::STAT_W-1:0]  rsp_stat_value,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [nvwb_pkg::CSR_W-1:0]   csr_wdata
);

   nvwb_pkg::cmd_type       cmd;
   nvwb_pkg::dp_status_type sts;

   nvwb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nvwb_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_op           (req_op),
      .req_block_id     (req_block_id),
      .req_same_as_last (req_same_as_last),
      .req_commit_ok    (req_commit_ok),
      .req_load_status  (req_load_status),
      .req_stat_select  (req_stat_select),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_block    (rsp_out_block),
      .rsp_status_code  (rsp_status_code),
      .rsp_accepted     (rsp_accepted),
      .rsp_dirty_count  (rsp_dirty_count),
      .rsp_stat_value   (rsp_stat_value),
      .rsp_last         (rsp_last)
   );

   // a captured request blocks the next one until its last result is loaded
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another was in progress");

   // the sequencer loads a result only into a free output register
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == nvwb_pkg::CMD_SINGLE || cmd == nvwb_pkg::CMD_IDLE_OK) |-> sts.slot_free)
      else $error("result loaded over an unread result");

   // commit commands always carry pending and accepted
   a_commit_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |->
         rsp_status_code == nvwb_pkg::ST_PENDING && rsp_accepted)
      else $error("malformed commit command");

   a_dirty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dirty_count <= 4'(nvwb_pkg::MGD_LIMIT))
      else $error("dirty count above managed limit");

endmodule
